### design/sed_pkg.sv
`timescale 1ns / 1ps

package sed_pkg;

    localparam int unsigned CHAR_W = 21;
    localparam int unsigned CODE_W = 32;

    localparam logic [CHAR_W-1:0] CH_BACKSLASH = CHAR_W'('h5C);
    localparam logic [CHAR_W-1:0] CH_LOWER_U   = CHAR_W'('h75);
    localparam logic [CHAR_W-1:0] CH_LOWER_A   = CHAR_W'('h61);
    localparam logic [CHAR_W-1:0] CH_LOWER_Z   = CHAR_W'('h7A);
    localparam logic [CHAR_W-1:0] CH_UPPER_A   = CHAR_W'('h41);
    localparam logic [CHAR_W-1:0] CH_UPPER_Z   = CHAR_W'('h5A);
    localparam logic [CHAR_W-1:0] CH_ZERO      = CHAR_W'('h30);
    localparam logic [CHAR_W-1:0] CH_LOWER_B   = CHAR_W'('h62);
    localparam logic [CHAR_W-1:0] CH_LOWER_F   = CHAR_W'('h66);
    localparam logic [CHAR_W-1:0] CH_LOWER_N   = CHAR_W'('h6E);
    localparam logic [CHAR_W-1:0] CH_LOWER_R   = CHAR_W'('h72);
    localparam logic [CHAR_W-1:0] CH_LOWER_T   = CHAR_W'('h74);

    localparam logic [CODE_W-1:0] CODE_BS  = CODE_W'(8);
    localparam logic [CODE_W-1:0] CODE_FF  = CODE_W'(12);
    localparam logic [CODE_W-1:0] CODE_LF  = CODE_W'(10);
    localparam logic [CODE_W-1:0] CODE_CR  = CODE_W'(13);
    localparam logic [CODE_W-1:0] CODE_TAB = CODE_W'(9);
    localparam logic [CODE_W-1:0] LETTER_OFFSET = CODE_W'(10);

    typedef struct packed {
        logic [CHAR_W-1:0] char_in;
        logic              end_of_string;
    } t_item;

    typedef struct packed {
        logic [CODE_W-1:0] char_out;
        logic              char_valid;
        logic              string_done;
    } t_result;

endpackage

### design/sed_in_stage.sv
`timescale 1ns / 1ps

module sed_in_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  sed_pkg::t_item i_item,
    output logic          o_valid,
    input  logic          i_ready,
    output sed_pkg::t_item o_item
);

    logic          r_valid;
    sed_pkg::t_item r_item;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

### design/sed_decoder.sv
`timescale 1ns / 1ps

module sed_decoder (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  sed_pkg::t_item   i_item,
    output logic             o_valid,
    input  logic             i_ready,
    output sed_pkg::t_result o_result
);

    typedef enum logic [1:0] {
        MODE_PLAIN = 2'd0,
        MODE_ESC   = 2'd1,
        MODE_HEX   = 2'd2
    } t_mode;

    t_mode                     r_mode, n_mode;
    logic [1:0]                r_left, n_left;
    logic [sed_pkg::CODE_W-1:0] r_acc, n_acc;

    logic                      has_result;
    logic                      advance;
    logic [sed_pkg::CODE_W-1:0] char_ext;
    logic [sed_pkg::CODE_W-1:0] digit;
    logic [sed_pkg::CODE_W-1:0] hex_sum;
    logic [sed_pkg::CODE_W-1:0] esc_code;
    logic [sed_pkg::CHAR_W-1:0] c;

    assign c        = i_item.char_in;
    assign char_ext = sed_pkg::CODE_W'(c);

    always_comb begin
        if (c >= sed_pkg::CH_LOWER_A && c <= sed_pkg::CH_LOWER_Z) begin
            digit = char_ext - sed_pkg::CODE_W'(sed_pkg::CH_LOWER_A) + sed_pkg::LETTER_OFFSET;
        end else if (c >= sed_pkg::CH_UPPER_A && c <= sed_pkg::CH_UPPER_Z) begin
            digit = char_ext - sed_pkg::CODE_W'(sed_pkg::CH_UPPER_A) + sed_pkg::LETTER_OFFSET;
        end else begin
            digit = char_ext - sed_pkg::CODE_W'(sed_pkg::CH_ZERO);
        end
    end

    assign hex_sum = r_acc + (digit << {r_left, 2'b00});

    always_comb begin
        if (c == sed_pkg::CH_LOWER_B) begin
            esc_code = sed_pkg::CODE_BS;
        end else if (c == sed_pkg::CH_LOWER_F) begin
            esc_code = sed_pkg::CODE_FF;
        end else if (c == sed_pkg::CH_LOWER_N) begin
            esc_code = sed_pkg::CODE_LF;
        end else if (c == sed_pkg::CH_LOWER_R) begin
            esc_code = sed_pkg::CODE_CR;
        end else if (c == sed_pkg::CH_LOWER_T) begin
            esc_code = sed_pkg::CODE_TAB;
        end else begin
            esc_code = char_ext;
        end
    end

    always_comb begin
        has_result = 1'b0;
        o_result   = '0;
        n_mode     = r_mode;
        n_left     = r_left;
        n_acc      = r_acc;
        if (i_item.end_of_string) begin
            has_result           = 1'b1;
            o_result.string_done = 1'b1;
            if (r_mode == MODE_HEX) begin
                o_result.char_out   = r_acc;
                o_result.char_valid = 1'b1;
            end
            n_mode = MODE_PLAIN;
            n_left = 2'd0;
            n_acc  = '0;
        end else begin
            unique case (r_mode)
                MODE_ESC: begin
                    if (c == sed_pkg::CH_LOWER_U) begin
                        n_mode = MODE_HEX;
                        n_left = 2'd3;
                        n_acc  = '0;
                    end else begin
                        n_mode              = MODE_PLAIN;
                        has_result          = 1'b1;
                        o_result.char_out   = esc_code;
                        o_result.char_valid = 1'b1;
                    end
                end
                MODE_HEX: begin
                    if (r_left == 2'd0) begin
                        n_mode              = MODE_PLAIN;
                        n_acc               = '0;
                        has_result          = 1'b1;
                        o_result.char_out   = hex_sum;
                        o_result.char_valid = 1'b1;
                    end else begin
                        n_left = r_left - 2'd1;
                        n_acc  = hex_sum;
                    end
                end
                default: begin
                    if (c == sed_pkg::CH_BACKSLASH) begin
                        n_mode = MODE_ESC;
                    end else begin
                        n_mode              = MODE_PLAIN;
                        has_result          = 1'b1;
                        o_result.char_out   = char_ext;
                        o_result.char_valid = 1'b1;
                    end
                end
            endcase
        end
    end

    assign o_ready = !has_result || i_ready;
    assign o_valid = i_valid && has_result;
    assign advance = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_PLAIN;
            r_left <= 2'd0;
            r_acc  <= '0;
        end else if (advance) begin
            r_mode <= n_mode;
            r_left <= n_left;
            r_acc  <= n_acc;
        end
    end

endmodule

### design/sed_out_stage.sv
`timescale 1ns / 1ps

module sed_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  sed_pkg::t_result i_result,
    output logic             o_valid,
    input  logic             i_ready,
    output sed_pkg::t_result o_result
);

    logic             r_valid;
    sed_pkg::t_result r_result;

    assign o_ready  = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_result <= i_result;
        end
    end

endmodule

### design/string_escape_decoder.sv
`timescale 1ns / 1ps

// Decodes backslash escapes in a character stream, one character per cycle
// unless the output stalls. Each input transfer is registered, decoded
// combinationally against the escape state (plain, after backslash, reading
// four \u digits), and the result goes to an output register.
// Only characters that complete a decoded symbol, and every end-of-string
// item, produce an output transfer; a backslash, a 'u' after it and the first
// three code point digits produce none. An end-of-string item flushes a
// partly read code point (digits at their positional weights) or reports
// char_valid low, and returns the decoder to plain text.

module string_escape_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [20:0] i_char_in,
    input  logic        i_end_of_string,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_char_out,
    output logic        o_char_valid,
    output logic        o_string_done
);

    sed_pkg::t_item   in_item;
    sed_pkg::t_item   reg_item;
    sed_pkg::t_result dec_result;
    sed_pkg::t_result out_result;
    logic             reg_valid, reg_ready;
    logic             dec_valid, out_ready;

    assign in_item.char_in       = i_char_in;
    assign in_item.end_of_string = i_end_of_string;

    sed_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (in_item),
        .o_valid (reg_valid),
        .i_ready (reg_ready),
        .o_item  (reg_item)
    );

    sed_decoder u_dec (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (reg_valid),
        .o_ready  (reg_ready),
        .i_item   (reg_item),
        .o_valid  (dec_valid),
        .i_ready  (out_ready),
        .o_result (dec_result)
    );

    sed_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (dec_valid),
        .o_ready  (out_ready),
        .i_result (dec_result),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (out_result)
    );

    assign o_char_out    = out_result.char_out;
    assign o_char_valid  = out_result.char_valid;
    assign o_string_done = out_result.string_done;

endmodule
